// ===== rtl/core/jsu_pkg.sv =====
// Package for the JSON string unescape block: transaction payload types,
// decode phase enum, character codes and the UTF-8 / hex helper functions.
// No dependencies.
package jsu_pkg;

   localparam int OUT_DEPTH = 6;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_end;
      logic       string_closed;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_PLAIN   = 3'd0,
      PH_ESC     = 3'd1,
      PH_HEX     = 3'd2,
      PH_LOW_BS  = 3'd3,
      PH_LOW_U   = 3'd4,
      PH_LOW_HEX = 3'd5
   } phase_type;

   // up to four encoded bytes and how many of them are used
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      cnt;
   } part_type;

   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_LOW_B  = 8'h62;
   localparam logic [7:0] CHR_LOW_F  = 8'h66;
   localparam logic [7:0] CHR_LOW_N  = 8'h6E;
   localparam logic [7:0] CHR_LOW_R  = 8'h72;
   localparam logic [7:0] CHR_LOW_T  = 8'h74;
   localparam logic [7:0] CHR_LOW_U  = 8'h75;

   localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
   localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
   localparam logic [31:0] SURR_LOW_BASE = 32'h0000_DC00;
   localparam logic [31:0] SUPP_BASE     = 32'h0001_0000;

   function automatic logic [3:0] hex_value(input logic [7:0] h);
      logic [3:0] v;
      begin
         v = 4'd0;
         if (h >= 8'h30 && h <= 8'h39) v = h[3:0];
         else if ((h >= 8'h61 && h <= 8'h66) || (h >= 8'h41 && h <= 8'h46))
            v = h[3:0] + 4'd9;
         return v;
      end
   endfunction

   function automatic part_type raw_part(input logic [7:0] b);
      part_type p;
      begin
         p       = '0;
         p.bytes[0] = b;
         p.cnt   = 3'd1;
         return p;
      end
   endfunction

   function automatic part_type utf8_part(input logic [31:0] cp);
      part_type p;
      begin
         p = '0;
         if (cp < 32'h80) begin
            p.bytes[0] = cp[7:0];
            p.cnt      = 3'd1;
         end else if (cp < 32'h800) begin
            p.bytes[0] = 8'hC0 | cp[13:6];
            p.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
            p.cnt      = 3'd2;
         end else if (cp < 32'h10000) begin
            p.bytes[0] = 8'hE0 | cp[19:12];
            p.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            p.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
            p.cnt      = 3'd3;
         end else begin
            p.bytes[0] = 8'hF0 | cp[25:18];
            p.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            p.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            p.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
            p.cnt      = 3'd4;
         end
         return p;
      end
   endfunction

endpackage

// ===== rtl/core/json_string_unescape_utf8_top.sv =====
// Top level of the JSON string unescape block: input register, decode logic
// and a six-entry result shift buffer. Depends on jsu_pkg.
//
// Usage:
//  - req channel: one raw byte of a JSON string body per transaction, starting
//    after the opening quote, with final_byte set on the last available byte.
//  - rsp channel: decoded bytes, one per transaction. string_end marks the last
//    result of a string and string_closed tells whether a closing quote ended
//    it. A string end with no decoded byte in that step gives one result with
//    byte_valid low and out_byte zero.
//  - \uXXXX escapes become UTF-8; surrogate pairs join when the low escape is
//    complete. One input byte causes zero to six results.
//  - Path: a byte waits in the input register, is decoded into the result buffer
//    once that is empty or its last result is taken, and is offered from entry 0.
//  - Throughput: one input byte per cycle while each byte gives at most one
//    result and rsp_ready stays high; a byte giving more results holds the next
//    byte until its last result is taken, as the buffer drains one per cycle.
//  - Bytes that give no result (a backslash, hex digits) never hold the next byte.
//  - Reset clears the decode state, empties the input register and the result
//    buffer, and holds req_ready low.
//  - When the receiver stalls, the buffer holds its results, the next byte
//    waits in the input register and req_ready drops once both are full.
module json_string_unescape_utf8_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;

   // decode state
   phase_type   phase_ff, phase_in;
   logic [1:0]  dc_ff, dc_in;
   logic [15:0] high_ff, high_in;
   logic [15:0] low_ff, low_in;

   // result buffer, entry 0 is the one offered
   logic [OUT_DEPTH-1:0][7:0] buf_ff, buf_in;
   logic [2:0] rem_ff, rem_in;
   logic       end_ff, end_in;
   logic       closed_ff, closed_in;
   logic       dummy_ff, dummy_in;

   logic load, pop, last;

   // decode signals
   logic [7:0]  b;
   logic        fin;
   logic [15:0] hex_word;
   logic [31:0] pair_cp;
   part_type    p1, p2;
   logic        end_hit, closed_hit;

   // outcome of a byte in the plain phase
   part_type plain_part;
   logic     plain_to_esc, plain_end, plain_closed;
   // outcome of a byte after a backslash
   part_type esc_part;
   logic     esc_to_hex;

   logic [3:0] total;
   logic [2:0] j;

   function automatic logic [9:0] high_in_offset(input logic [15:0] h);
      logic [15:0] d;
      begin
         d = h - SURR_HIGH_MIN;
         return d[9:0];
      end
   endfunction

   assign b   = in_data_ff.in_byte;
   assign fin = in_data_ff.final_byte;

   assign last      = (rem_ff == 3'd1);
   assign rsp_valid = (rem_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign load      = in_valid_ff && (!rsp_valid || (pop && last));
   assign req_ready = !reset && (!in_valid_ff || load);

   assign rsp_data.out_byte      = buf_ff[0];
   assign rsp_data.byte_valid    = !dummy_ff;
   assign rsp_data.string_end    = end_ff && last;
   assign rsp_data.string_closed = closed_ff && end_ff && last;

   always_comb begin
      plain_part   = '0;
      plain_to_esc = 1'b0;
      plain_end    = 1'b0;
      plain_closed = 1'b0;
      if (b == CHR_QUOTE) begin
         plain_end    = 1'b1;
         plain_closed = 1'b1;
      end else if (b == CHR_BSLASH) begin
         plain_end    = fin;
         plain_to_esc = !fin;
      end else begin
         plain_part = raw_part(b);
         plain_end  = fin;
      end
   end

   always_comb begin
      esc_to_hex = 1'b0;
      case (b)
         CHR_LOW_B: esc_part = raw_part(8'h08);
         CHR_LOW_F: esc_part = raw_part(8'h0C);
         CHR_LOW_N: esc_part = raw_part(8'h0A);
         CHR_LOW_R: esc_part = raw_part(8'h0D);
         CHR_LOW_T: esc_part = raw_part(8'h09);
         CHR_LOW_U: begin
            // a \u cut off by the end of input encodes value zero
            esc_part   = fin ? raw_part(8'h00) : '0;
            esc_to_hex = !fin;
         end
         default:   esc_part = raw_part(b);
      endcase
   end

   assign hex_word = {(phase_ff == PH_LOW_HEX) ? low_ff[11:0] : high_ff[11:0], hex_value(b)};
   assign pair_cp  = SUPP_BASE + {12'd0, high_in_offset(high_ff), 10'd0}
                     + {16'd0, hex_word} - SURR_LOW_BASE;

   always_comb begin
      phase_in   = phase_ff;
      dc_in      = dc_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      p1         = '0;
      p2         = '0;
      end_hit    = 1'b0;
      closed_hit = 1'b0;
      case (phase_ff)
         PH_ESC: begin
            p1      = esc_part;
            end_hit = fin;
            if (esc_to_hex) begin
               phase_in = PH_HEX;
               dc_in    = 2'd0;
               high_in  = 16'd0;
            end else begin
               phase_in = PH_PLAIN;
            end
         end
         PH_HEX: begin
            high_in = hex_word;
            if (dc_ff == 2'd3) begin
               dc_in = 2'd0;
               if (hex_word >= SURR_HIGH_MIN && hex_word <= SURR_HIGH_MAX && !fin) begin
                  phase_in = PH_LOW_BS;
               end else begin
                  p1       = utf8_part({16'd0, hex_word});
                  phase_in = PH_PLAIN;
                  end_hit  = fin;
               end
            end else begin
               dc_in = dc_ff + 2'd1;
               if (fin) begin
                  p1      = utf8_part({16'd0, hex_word});
                  end_hit = 1'b1;
               end
            end
         end
         PH_LOW_BS: begin
            if (b == CHR_BSLASH && !fin) begin
               phase_in = PH_LOW_U;
            end else begin
               // flush the lone high half, then treat the byte as plain
               p1         = utf8_part({16'd0, high_ff});
               p2         = plain_part;
               phase_in   = plain_to_esc ? PH_ESC : PH_PLAIN;
               end_hit    = plain_end;
               closed_hit = plain_closed;
            end
         end
         PH_LOW_U: begin
            if (b == CHR_LOW_U && !fin) begin
               phase_in = PH_LOW_HEX;
               dc_in    = 2'd0;
               low_in   = 16'd0;
            end else begin
               p1      = utf8_part({16'd0, high_ff});
               p2      = esc_part;
               end_hit = fin;
               if (esc_to_hex) begin
                  phase_in = PH_HEX;
                  dc_in    = 2'd0;
                  high_in  = 16'd0;
               end else begin
                  phase_in = PH_PLAIN;
               end
            end
         end
         PH_LOW_HEX: begin
            low_in = hex_word;
            if (dc_ff == 2'd3) begin
               p1       = utf8_part(pair_cp);
               phase_in = PH_PLAIN;
               dc_in    = 2'd0;
               end_hit  = fin;
            end else begin
               dc_in = dc_ff + 2'd1;
               if (fin) begin
                  p1      = utf8_part({16'd0, high_ff});
                  p2      = utf8_part({16'd0, hex_word});
                  end_hit = 1'b1;
               end
            end
         end
         default: begin
            p1         = plain_part;
            phase_in   = plain_to_esc ? PH_ESC : PH_PLAIN;
            end_hit    = plain_end;
            closed_hit = plain_closed;
         end
      endcase
      // end of string: drop all decode state
      if (end_hit) begin
         phase_in = PH_PLAIN;
         dc_in    = 2'd0;
         high_in  = 16'd0;
         low_in   = 16'd0;
      end
   end

   assign total = {1'b0, p1.cnt} + {1'b0, p2.cnt};

   // result buffer next state: load a decoded step, or shift on a pop
   always_comb begin
      buf_in    = buf_ff;
      rem_in    = rem_ff;
      end_in    = end_ff;
      closed_in = closed_ff;
      dummy_in  = dummy_ff;
      j         = 3'd0;
      if (load) begin
         for (int i = 0; i < OUT_DEPTH; i++) begin
            buf_in[i] = 8'd0;
            if (i < 4 && 3'(i) < p1.cnt) begin
               buf_in[i] = p1.bytes[i[1:0]];
            end else begin
               j = 3'(i) - p1.cnt;
               if (j < 3'd4 && j < p2.cnt) buf_in[i] = p2.bytes[j[1:0]];
            end
         end
         end_in    = end_hit;
         closed_in = closed_hit;
         if (total == 4'd0 && end_hit) begin
            rem_in   = 3'd1;
            dummy_in = 1'b1;
         end else begin
            rem_in   = total[2:0];
            dummy_in = 1'b0;
         end
      end else if (pop) begin
         for (int i = 0; i < OUT_DEPTH - 1; i++) buf_in[i] = buf_ff[i + 1];
         buf_in[OUT_DEPTH-1] = 8'd0;
         rem_in = rem_ff - 3'd1;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) in_valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_PLAIN;
         dc_ff       <= 2'd0;
         high_ff     <= 16'd0;
         low_ff      <= 16'd0;
         rem_ff      <= 3'd0;
         end_ff      <= 1'b0;
         closed_ff   <= 1'b0;
         dummy_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (load) begin
            phase_ff <= phase_in;
            dc_ff    <= dc_in;
            high_ff  <= high_in;
            low_ff   <= low_in;
         end
         rem_ff    <= rem_in;
         end_ff    <= end_in;
         closed_ff <= closed_in;
         dummy_ff  <= dummy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_data_ff <= req_data;
      buf_ff <= buf_in;
   end

endmodule

// ===== verif/tb_json_string_unescape_utf8_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for json_string_unescape_utf8_top: a directed table, then random
// escape sequences, whole and broken, checked against a behavioral decoder kept here.
// Depends on jsu_pkg and the RTL only.
module tb_json_string_unescape_utf8_top;
   import jsu_pkg::*;

   localparam int WATCHDOG_LIMIT = 400;
   localparam int RANDOM_ITEMS   = 175;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DIRECTED_ROWS  = 27;

   // ASCII and UTF-8 codes the package does not name
   localparam logic [7:0] CHR_SLASH     = 8'h2F;
   localparam logic [7:0] CHR_DIGIT0    = 8'h30;
   localparam logic [7:0] CHR_DIGIT9    = 8'h39;
   localparam logic [7:0] CHR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHR_UPPER_F   = 8'h46;
   localparam logic [7:0] CHR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHR_LOWER_F   = 8'h66;
   localparam logic [7:0] CTL_BACKSPACE = 8'h08;
   localparam logic [7:0] CTL_TAB       = 8'h09;
   localparam logic [7:0] CTL_NEWLINE   = 8'h0A;
   localparam logic [7:0] CTL_FORMFEED  = 8'h0C;
   localparam logic [7:0] CTL_RETURN    = 8'h0D;
   localparam logic [7:0] UTF8_CONT     = 8'h80;
   localparam logic [7:0] UTF8_LEAD2    = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3    = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4    = 8'hF0;
   localparam logic [31:0] UTF8_MASK6   = 32'h3F;
   localparam logic [31:0] UTF8_LIMIT1  = 32'h80;
   localparam logic [31:0] UTF8_LIMIT2  = 32'h800;

   localparam rsp_type NO_RESULT = '0;

   // One input byte of the plan; when typed is set, want is the single result it must give,
   // otherwise the decoder below works out what to expect.
   typedef struct packed {
      logic [7:0] chr;
      logic       last;
      logic       typed;
      rsp_type    want;
   } script_row;

   localparam script_row DIRECTED [DIRECTED_ROWS] = '{
      '{8'h41,      1'b0, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0}},          // plain 'A'
      '{8'h00,      1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},          // lowest byte
      '{8'hFF,      1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},          // highest byte
      '{CHR_QUOTE,  1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},          // empty close
      '{CHR_BSLASH, 1'b0, 1'b0, NO_RESULT},
      '{CHR_LOW_N,  1'b0, 1'b1, '{CTL_NEWLINE, 1'b1, 1'b0, 1'b0}},
      // \uD83D\ude00: surrogate pair joined into four bytes
      '{CHR_BSLASH, 1'b0, 1'b0, NO_RESULT},
      '{CHR_LOW_U,  1'b0, 1'b0, NO_RESULT},
      '{8'h44,      1'b0, 1'b0, NO_RESULT},
      '{8'h38,      1'b0, 1'b0, NO_RESULT},
      '{8'h33,      1'b0, 1'b0, NO_RESULT},
      '{8'h44,      1'b0, 1'b0, NO_RESULT},
      '{CHR_BSLASH, 1'b0, 1'b0, NO_RESULT},
      '{CHR_LOW_U,  1'b0, 1'b0, NO_RESULT},
      '{8'h64,      1'b0, 1'b0, NO_RESULT},
      '{8'h65,      1'b0, 1'b0, NO_RESULT},
      '{8'h30,      1'b0, 1'b0, NO_RESULT},
      '{8'h30,      1'b0, 1'b0, NO_RESULT},
      // \ugF with the input ending: non-hex digit as zero, partial value flushed
      '{CHR_BSLASH, 1'b0, 1'b0, NO_RESULT},
      '{CHR_LOW_U,  1'b0, 1'b0, NO_RESULT},
      '{8'h67,      1'b0, 1'b0, NO_RESULT},
      '{8'h46,      1'b1, 1'b0, NO_RESULT},
      // input ending right on a backslash gives a bare end
      '{CHR_BSLASH, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      // unknown escape gives the character itself
      '{CHR_BSLASH, 1'b0, 1'b0, NO_RESULT},
      '{8'h71,      1'b1, 1'b1, '{8'h71, 1'b1, 1'b1, 1'b0}},
      // input ending right after \u encodes zero
      '{CHR_BSLASH, 1'b0, 1'b0, NO_RESULT},
      '{CHR_LOW_U,  1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   script_row byte_plan[$];
   rsp_type   decoded_due[$];   // results still owed by the block, oldest first
   rsp_type   step_bytes[$];    // results of the byte being decoded

   // decoder state
   phase_type   scan_phase  = PH_PLAIN;
   logic [1:0]  digits_seen = '0;
   logic [15:0] high_unit   = '0;
   logic [15:0] low_unit    = '0;

   int bytes_taken  = 0;
   int results_seen = 0;
   int ends_quoted  = 0;
   int ends_open    = 0;
   int mismatches   = 0;
   int quiet_cycles = 0;

   always #10 clock = ~clock;

   json_string_unescape_utf8_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------- decoder

   function automatic logic [3:0] hex_nibble(input logic [7:0] chr);
      if (chr >= CHR_DIGIT0 && chr <= CHR_DIGIT9) return 4'(chr - CHR_DIGIT0);
      if (chr >= CHR_LOWER_A && chr <= CHR_LOWER_F) return 4'(chr - CHR_LOWER_A + 8'd10);
      if (chr >= CHR_UPPER_A && chr <= CHR_UPPER_F) return 4'(chr - CHR_UPPER_A + 8'd10);
      return 4'd0;
   endfunction

   // Append one decoded byte; anything past the result buffer depth is dropped.
   task automatic emit(input logic [7:0] value);
      if (step_bytes.size() < OUT_DEPTH) step_bytes.push_back('{value, 1'b1, 1'b0, 1'b0});
   endtask

   // Mark the string end on the last result of the step, or on an empty one, and start over.
   task automatic close_string(input logic quoted);
      rsp_type tail;
      if (step_bytes.size() == 0) tail = NO_RESULT;
      else tail = step_bytes.pop_back();
      tail.string_end    = 1'b1;
      tail.string_closed = quoted;
      step_bytes.push_back(tail);
      scan_phase  = PH_PLAIN;
      digits_seen = '0;
      high_unit   = '0;
      low_unit    = '0;
   endtask

   task automatic emit_utf8(input logic [31:0] cp);
      if (cp < UTF8_LIMIT1) begin
         emit(cp[7:0]);
      end else if (cp < UTF8_LIMIT2) begin
         emit(8'(UTF8_LEAD2 | (cp >> 6)));
         emit(8'(UTF8_CONT | (cp & UTF8_MASK6)));
      end else if (cp < SUPP_BASE) begin
         emit(8'(UTF8_LEAD3 | (cp >> 12)));
         emit(8'(UTF8_CONT | ((cp >> 6) & UTF8_MASK6)));
         emit(8'(UTF8_CONT | (cp & UTF8_MASK6)));
      end else begin
         emit(8'(UTF8_LEAD4 | (cp >> 18)));
         emit(8'(UTF8_CONT | ((cp >> 12) & UTF8_MASK6)));
         emit(8'(UTF8_CONT | ((cp >> 6) & UTF8_MASK6)));
         emit(8'(UTF8_CONT | (cp & UTF8_MASK6)));
      end
   endtask

   task automatic plain_char(input logic [7:0] chr, input logic fin);
      if (chr == CHR_QUOTE) begin
         close_string(1'b1);
      end else if (chr == CHR_BSLASH) begin
         if (fin) close_string(1'b0);
         else scan_phase = PH_ESC;
      end else begin
         emit(chr);
         if (fin) close_string(1'b0);
      end
   endtask

   task automatic escaped_char(input logic [7:0] chr, input logic fin);
      scan_phase = PH_PLAIN;
      case (chr)
         CHR_LOW_B: emit(CTL_BACKSPACE);
         CHR_LOW_F: emit(CTL_FORMFEED);
         CHR_LOW_N: emit(CTL_NEWLINE);
         CHR_LOW_R: emit(CTL_RETURN);
         CHR_LOW_T: emit(CTL_TAB);
         CHR_LOW_U: begin
            if (fin) begin
               emit_utf8(32'd0);
            end else begin
               scan_phase  = PH_HEX;
               digits_seen = '0;
               high_unit   = '0;
            end
         end
         default: emit(chr);
      endcase
      if (fin) close_string(1'b0);
   endtask

   // Decode one accepted byte into step_bytes and advance the decoder state.
   task automatic unescape_byte(input logic [7:0] chr, input logic fin);
      logic [31:0] cp;
      case (scan_phase)
         PH_ESC: escaped_char(chr, fin);
         PH_HEX: begin
            high_unit = {high_unit[11:0], hex_nibble(chr)};
            if (digits_seen == 2'd3) begin
               digits_seen = '0;
               if (high_unit >= SURR_HIGH_MIN && high_unit <= SURR_HIGH_MAX && !fin) begin
                  scan_phase = PH_LOW_BS;
               end else begin
                  emit_utf8({16'h0, high_unit});
                  scan_phase = PH_PLAIN;
                  if (fin) close_string(1'b0);
               end
            end else begin
               digits_seen++;
               if (fin) begin
                  emit_utf8({16'h0, high_unit});
                  close_string(1'b0);
               end
            end
         end
         PH_LOW_BS: begin
            if (chr == CHR_BSLASH && !fin) begin
               scan_phase = PH_LOW_U;
            end else begin
               // high half stands alone, then the byte is ordinary input
               emit_utf8({16'h0, high_unit});
               scan_phase = PH_PLAIN;
               plain_char(chr, fin);
            end
         end
         PH_LOW_U: begin
            if (chr == CHR_LOW_U && !fin) begin
               scan_phase  = PH_LOW_HEX;
               digits_seen = '0;
               low_unit    = '0;
            end else begin
               emit_utf8({16'h0, high_unit});
               escaped_char(chr, fin);
            end
         end
         PH_LOW_HEX: begin
            low_unit = {low_unit[11:0], hex_nibble(chr)};
            if (digits_seen == 2'd3) begin
               // low half is not range checked, so this wraps at 32 bits
               cp = SUPP_BASE + (({16'h0, high_unit} - {16'h0, SURR_HIGH_MIN}) << 10)
                    + ({16'h0, low_unit} - SURR_LOW_BASE);
               emit_utf8(cp);
               scan_phase  = PH_PLAIN;
               digits_seen = '0;
               if (fin) close_string(1'b0);
            end else begin
               digits_seen++;
               if (fin) begin
                  emit_utf8({16'h0, high_unit});
                  emit_utf8({16'h0, low_unit});
                  close_string(1'b0);
               end
            end
         end
         default: begin
            scan_phase = PH_PLAIN;
            plain_char(chr, fin);
         end
      endcase
   endtask

   // -------------------------------------------------------- stimulus helpers

   // Queue a byte; a small share of bytes end the input wherever they fall.
   task automatic add_byte(input logic [7:0] chr, input logic stop);
      byte_plan.push_back('{chr, stop || ($urandom_range(0, 24) == 0), 1'b0, NO_RESULT});
   endtask

   // Hex digit in either case, now and then a random byte that decodes as zero unless it is a hex digit.
   function automatic logic [7:0] digit_char(input logic [3:0] v);
      if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
      if (v < 4'd10) return CHR_DIGIT0 + 8'(v);
      return ($urandom_range(0, 1) ? CHR_LOWER_A : CHR_UPPER_A) + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] escape_char();
      case ($urandom_range(0, 9))
         0: return CHR_LOW_B;
         1: return CHR_LOW_F;
         2: return CHR_LOW_N;
         3: return CHR_LOW_R;
         4: return CHR_LOW_T;
         5: return CHR_QUOTE;
         6: return CHR_BSLASH;
         7: return CHR_SLASH;
         8: return CHR_LOW_U;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_unicode(input logic [15:0] code);
      add_byte(CHR_BSLASH, 1'b0);
      add_byte(CHR_LOW_U, 1'b0);
      for (int i = 3; i >= 0; i--) add_byte(digit_char(code[i*4 +: 4]), 1'b0);
   endtask

   // Hold the sender off until the block owes nothing; sample at the falling edge so the
   // scoreboard has settled.
   task automatic wait_drained();
      do @(negedge clock); while (decoded_due.size() != 0);
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("result %0d %s: expected %0h, got %0h", results_seen, name, want, got);
         mismatches++;
      end
   endtask

   // -------------------------------------------------------------- scoreboard

   // Predict on every accepted input transaction and check every accepted result
   // transaction. Both are sampled at the rising edge, before this edge's drives land.
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      logic    moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            moved = 1'b1;
            step_bytes.delete();
            unescape_byte(req_data.in_byte, req_data.final_byte);
            // typed rows carry their own answer; the decoder state still advances
            if (byte_plan[bytes_taken].typed) decoded_due.push_back(byte_plan[bytes_taken].want);
            else foreach (step_bytes[k]) decoded_due.push_back(step_bytes[k]);
            bytes_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            results_seen++;
            if (decoded_due.size() == 0) begin
               $error("result %0d arrived with nothing expected", results_seen);
               mismatches++;
            end else begin
               want = decoded_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_data.byte_valid));
               check_field("string_end", 8'(want.string_end), 8'(rsp_data.string_end));
               check_field("string_closed", 8'(want.string_closed), 8'(rsp_data.string_closed));
            end
            if (rsp_data.string_end === 1'b1) begin
               if (rsp_data.string_closed === 1'b1) ends_quoted++;
               else ends_open++;
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // ----------------------------------------------------------------- receiver

   // Stall for a random draw before each result, with calm stretches of no stalls.
   initial begin : result_sink
      int stall;
      int draws;
      bit calm;
      draws = 0;
      calm  = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (draws % 16 == 0) calm = ($urandom_range(0, 3) == 0);
         draws++;
         stall = calm ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ----------------------------------------------------------------- watchdog

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_json_string_unescape_utf8_top failed");
      $finish;
   end

   // ------------------------------------------------------------------- sender

   initial begin : stimulus
      logic [15:0] code;
      int          gap;
      bit          calm;
      bit          pause;

      foreach (DIRECTED[i]) byte_plan.push_back(DIRECTED[i]);

      // Random part: mostly whole escapes with random content, plus raw bytes, quotes
      // and lone high halves followed by whatever breaks the pair.
      while (byte_plan.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: add_byte(8'($urandom_range(0, 255)), 1'b0);
            3, 4: begin
               add_byte(CHR_BSLASH, 1'b0);
               add_byte(escape_char(), 1'b0);
            end
            5, 6: begin
               case ($urandom_range(0, 3))
                  0: code = 16'($urandom_range(0, 'h7F));
                  1: code = 16'($urandom_range('h80, 'h7FF));
                  2: code = 16'($urandom);
                  default: code = SURR_HIGH_MIN | 16'($urandom_range(0, 'h3FF));
               endcase
               add_unicode(code);
            end
            7: begin
               // pair; the low half is often outside its own range
               add_unicode(SURR_HIGH_MIN | 16'($urandom_range(0, 'h3FF)));
               if ($urandom_range(0, 1)) code = SURR_LOW_BASE[15:0] | 16'($urandom_range(0, 'h3FF));
               else code = 16'($urandom);
               add_unicode(code);
            end
            8: begin
               add_unicode(SURR_HIGH_MIN | 16'($urandom_range(0, 'h3FF)));
               case ($urandom_range(0, 3))
                  0: add_byte(8'($urandom_range(0, 255)), 1'b0);
                  1: begin
                     add_byte(CHR_BSLASH, 1'b0);
                     add_byte(escape_char(), 1'b0);
                  end
                  2: begin
                     // input runs out inside the low digits
                     add_byte(CHR_BSLASH, 1'b0);
                     add_byte(CHR_LOW_U, 1'b0);
                     repeat ($urandom_range(0, 2)) add_byte(digit_char(4'($urandom)), 1'b0);
                     add_byte(digit_char(4'($urandom)), 1'b1);
                  end
                  default: add_byte(CHR_QUOTE, 1'b0);
               endcase
            end
            default: add_byte(CHR_QUOTE, 1'b0);
         endcase
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the plan. Hold valid and payload until accepted; drop valid only for a gap,
      // so it is never lowered and raised in one step.
      calm = 1'b0;
      for (int idx = 0; idx < byte_plan.size(); idx++) begin
         if (idx % 16 == 0) calm = ($urandom_range(0, 3) == 0);
         gap   = calm ? 0 : $urandom_range(0, 7);
         pause = (idx == DIRECTED_ROWS) || ($urandom_range(0, 63) == 0);
         if (gap != 0 || pause) begin
            req_valid <= 1'b0;
            if (pause) wait_drained();
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= '{byte_plan[idx].chr, byte_plan[idx].last};
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      // Drain, then let the pipeline settle so that any stray result shows.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (decoded_due.size() != 0) begin
         $error("%0d expected results never arrived", decoded_due.size());
         mismatches++;
      end

      $display("Sent %0d input bytes (%0d from the directed table), checked %0d results.",
               bytes_taken, DIRECTED_ROWS, results_seen);
      $display("Strings closed by a quote: %0d, cut off by a final byte: %0d.",
               ends_quoted, ends_open);
      if (mismatches == 0) begin
         $display("tb_json_string_unescape_utf8_top passed");
      end else begin
         $display("tb_json_string_unescape_utf8_top failed");
      end
      $finish;
   end

endmodule
